>>> rtl/q4bd_pkg.sv
// Package for the Q4 block dequantizer: sizes, lane request struct and
// the scale-times-code conversion to single precision. No dependencies.
package q4bd_pkg;

    localparam int BLOCK_ELEMS = 32;
    localparam int HALF_ELEMS  = 16;
    localparam logic [3:0] CODE_OFFSET = 4'd8;

    typedef struct packed {
        logic [15:0] scale;
        logic [3:0]  code;
    } t_lane_req;

    // Mantissa product is at most 11 x 4 bits; the leading-one search
    // runs over 14 bits, each step an independent compare.
    function automatic logic [31:0] scaled_bits(input logic [15:0] h, input logic [3:0] code);
        logic        hs;
        logic [4:0]  he;
        logic [9:0]  hm;
        logic        neg;
        logic [3:0]  mag;
        logic        sgn;
        logic [10:0] p11;
        logic [13:0] p;
        logic [4:0]  k;
        logic [7:0]  ex;
        logic [36:0] sh;
        logic [31:0] res;
        hs  = h[15];
        he  = h[14:10];
        hm  = h[9:0];
        neg = (code < CODE_OFFSET);
        mag = neg ? (CODE_OFFSET - code) : (code - CODE_OFFSET);
        sgn = hs ^ neg;
        p11 = (he == 5'd0) ? {1'b0, hm} : {1'b1, hm};
        p   = 14'(p11 * mag);
        k   = 5'd0;
        for (int j = 1; j < 14; j++) begin
            if (p[j]) k = 5'(j);
        end
        // Exponent: k + e2 + 127 where e2 = -24 (subnormal) or he - 25.
        ex  = (he == 5'd0) ? 8'(k + 5'd0 + 8'd103) : 8'({3'd0, he} + {3'd0, k} + 8'd102);
        sh  = {23'd0, p} << (5'd23 - k);
        if (he == 5'h1F) begin
            if (hm != 10'd0)      res = {hs, 8'hFF, hm | 10'h200, 13'd0};
            else if (mag == 4'd0) res = 32'h7FC00000;
            else                  res = {sgn, 8'hFF, 23'd0};
        end else if (p == 14'd0) begin
            res = {sgn, 31'd0};
        end else begin
            res = {sgn, ex, sh[22:0]};
        end
        return res;
    endfunction

endpackage

>>> rtl/q4bd_lane.sv
// One dequantizer lane: registered scale-times-code conversion.
// Depends on q4bd_pkg.
module q4bd_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  q4bd_pkg::t_lane_req  i_req,
    output logic [31:0]          o_value
);
    logic [31:0] r_value;
    always_ff @(posedge i_clk) begin
        if (i_en) r_value <= q4bd_pkg::scaled_bits(i_req.scale, i_req.code);
    end
    assign o_value = r_value;
endmodule

>>> rtl/q4bd_merge.sv
// Merge stage: holds a block's lane results; emits one per cycle while ready.
// Depends on q4bd_pkg.
module q4bd_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_final,
    input  logic [31:0]       i_lane_val [q4bd_pkg::BLOCK_ELEMS],
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_value_bits,
    output logic [4:0]        o_position,
    output logic              o_block_done,
    output logic              o_row_done
);
    localparam int LANES = q4bd_pkg::BLOCK_ELEMS;

    logic        r_valid, n_valid;
    logic [4:0]  r_pos, n_pos;
    logic        r_final;
    logic [31:0] r_vals [LANES];
    logic        last;

    wire fire = r_valid && i_ready;
    assign last    = fire && (r_pos == 5'(LANES - 1));
    assign o_busy  = r_valid && !last;

    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        if (fire) begin
            n_pos = r_pos + 5'd1;
            if (r_pos == 5'(LANES - 1)) n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_pos   = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 5'd0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
        if (i_load) begin
            r_final <= i_final;
            r_vals  <= i_lane_val;
        end
    end

    assign o_valid      = r_valid;
    assign o_value_bits = r_vals[r_pos];
    assign o_position   = r_pos;
    assign o_block_done = (r_pos == 5'(LANES - 1));
    assign o_row_done   = o_block_done && r_final;
endmodule

>>> rtl/q4_block_dequantizer.sv
// Top level of the Q4 block dequantizer: 32 conversion lanes and a merge stage.
// Depends on q4bd_pkg, q4bd_lane and q4bd_merge.
// A block is accepted whole, converted by 32 parallel lanes in one
// registered stage, then its 32 results leave one per cycle in element order
// while i_ready is high. The block rate is set by the single output port; the
// next block is accepted while the previous one drains, so blocks stream
// back to back with no gap. A block passes the lane register, then the merge one.
module q4_block_dequantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_scale_half,
    input  logic [63:0] i_quant_bytes_lo,
    input  logic [63:0] i_quant_bytes_hi,
    input  logic        i_final_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value_bits,
    output logic [4:0]  o_position,
    output logic        o_block_done,
    output logic        o_row_done
);
    localparam int N = q4bd_pkg::BLOCK_ELEMS;

    logic        r_stg, n_stg;
    logic        r_final;
    logic [31:0] lane_val [N];
    logic        busy, load;
    logic        in_fire;
    logic [127:0] bytes;

    assign bytes = {i_quant_bytes_hi, i_quant_bytes_lo};
    // Lane stage empties when the merge stage is free or frees this cycle.
    assign load    = r_stg && !busy;
    assign o_ready = !r_stg || load;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        n_stg = r_stg;
        if (load)    n_stg = 1'b0;
        if (in_fire) n_stg = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stg <= 1'b0;
        else          r_stg <= n_stg;
        if (in_fire)  r_final <= i_final_block;
    end

    for (genvar g = 0; g < N; g++) begin : g_lane
        q4bd_pkg::t_lane_req req;
        localparam int B = g % q4bd_pkg::HALF_ELEMS;
        assign req.scale = i_scale_half;
        assign req.code  = (g < q4bd_pkg::HALF_ELEMS) ? bytes[8*B +: 4] : bytes[8*B+4 +: 4];
        q4bd_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (in_fire),
            .i_req  (req),
            .o_value(lane_val[g])
        );
    end

    q4bd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_final     (r_final),
        .i_lane_val  (lane_val),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value_bits(o_value_bits),
        .o_position  (o_position),
        .o_block_done(o_block_done),
        .o_row_done  (o_row_done)
    );
endmodule

>>> rtl/q4bd_checker.sv
// Port-level checker for the Q4 block dequantizer, bound to the top level.
// Depends on q4_block_dequantizer ports only.
module q4bd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value_bits,
    input logic [4:0]  o_position,
    input logic        o_block_done,
    input logic        o_row_done
);
    a_pos_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_block_done |=> !o_valid || o_position == $past(o_position) + 5'd1)
        else $error("position skipped");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_block_done == (o_position == 5'd31))
        else $error("block_done misplaced");
    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_row_done |-> o_block_done)
        else $error("row_done without block_done");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value_bits) && $stable(o_position))
        else $error("stalled result changed");
endmodule

bind q4_block_dequantizer q4bd_checker u_q4bd_checker (.*);
